### hdl/mmwcd_pkg.sv
// Shared types and constants for the min/max waveform column decimator.
`timescale 1ns / 1ps

package mmwcd_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int ZOOM_W       = 40;
    localparam int ACC_W        = 56;
    localparam int FRAC_W       = 16;
    localparam int GAIN_W       = 24;
    localparam int ROW_W        = 12;
    localparam int COUNT_W      = 13;
    localparam int COL_W        = 12;
    localparam int SCALED_W     = 17;
    localparam int OUT_W        = 16;
    localparam int CFG_IDX_W    = 2;

    localparam logic [ZOOM_W-1:0]  ZOOM_RESET  = 40'd131072;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd256;
    localparam logic [ROW_W-1:0]   ROW_RESET   = 12'd0;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_CEIL  = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_FLOOR = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_PIXEL = 2'd0,
        CFG_VERTICAL_GAIN     = 2'd1,
        CFG_MIDDLE_ROW        = 2'd2,
        CFG_COLUMN_COUNT      = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] audio_value;
        logic                           frame_start;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [OUT_W-1:0] top_row;
        logic signed [OUT_W-1:0] bottom_row;
    } t_out_word;

    // One finished column on its way to scaling.
    typedef struct packed {
        logic [COUNT_W-1:0]             index;
        logic signed [SAMPLE_WIDTH-1:0] run_min;
        logic signed [SAMPLE_WIDTH-1:0] run_max;
        logic                           first;
    } t_col_event;

endpackage

### hdl/mmwcd_tracker.sv
// Sample tracker: running min/max, column end detection and column event register.
`timescale 1ns / 1ps

module mmwcd_tracker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  mmwcd_pkg::t_in_word         i_word,
    input  logic                        i_advance,
    input  logic [mmwcd_pkg::ZOOM_W-1:0]  i_samples_per_pixel,
    input  logic [mmwcd_pkg::COUNT_W-1:0] i_limit,
    output logic                        o_event_valid,
    output mmwcd_pkg::t_col_event       o_event
);
    import mmwcd_pkg::*;

    logic [ZOOM_W-1:0]              r_pos, n_pos;
    logic [ACC_W-1:0]               r_acc, n_acc;
    logic [COUNT_W-1:0]             r_idx, n_idx;
    logic signed [SAMPLE_WIDTH-1:0] r_min, n_min;
    logic signed [SAMPLE_WIDTH-1:0] r_max, n_max;
    logic                           r_first, n_first;
    logic                           r_ev_valid, n_ev_valid;
    t_col_event                     r_ev, n_ev;

    logic [ZOOM_W-1:0]              eff_pos;
    logic [ACC_W-1:0]               eff_acc;
    logic [COUNT_W-1:0]             eff_idx;
    logic signed [SAMPLE_WIDTH-1:0] eff_min, eff_max, lo, hi;
    logic                           eff_first;

    always_comb begin
        // A frame start restarts the state before the sample is taken in.
        if (i_word.frame_start) begin
            eff_pos   = '0;
            eff_acc   = ACC_W'(i_samples_per_pixel);
            eff_idx   = '0;
            eff_min   = SAMPLE_CEIL;
            eff_max   = SAMPLE_FLOOR;
            eff_first = 1'b1;
        end else begin
            eff_pos   = r_pos;
            eff_acc   = r_acc;
            eff_idx   = r_idx;
            eff_min   = r_min;
            eff_max   = r_max;
            eff_first = r_first;
        end
        lo = (i_word.audio_value < eff_min) ? i_word.audio_value : eff_min;
        hi = (i_word.audio_value > eff_max) ? i_word.audio_value : eff_max;

        n_pos      = r_pos;
        n_acc      = r_acc;
        n_idx      = r_idx;
        n_min      = r_min;
        n_max      = r_max;
        n_first    = r_first;
        n_ev_valid = i_advance ? 1'b0 : r_ev_valid;
        n_ev       = r_ev;

        if (i_take) begin
            n_pos   = eff_pos;
            n_acc   = eff_acc;
            n_idx   = eff_idx;
            n_min   = eff_min;
            n_max   = eff_max;
            n_first = eff_first;
            if (eff_idx < i_limit) begin
                n_pos = eff_pos + 1'b1;
                if (eff_pos < eff_acc[ACC_W-1:FRAC_W]) begin
                    n_min = lo;
                    n_max = hi;
                end else begin
                    n_ev_valid    = 1'b1;
                    n_ev.index    = eff_idx;
                    n_ev.run_min  = lo;
                    n_ev.run_max  = hi;
                    n_ev.first    = eff_first;
                    n_min         = SAMPLE_CEIL;
                    n_max         = SAMPLE_FLOOR;
                    n_idx         = eff_idx + 1'b1;
                    n_acc         = eff_acc + ACC_W'(i_samples_per_pixel);
                    n_first       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_acc      <= ACC_W'(ZOOM_RESET);
            r_idx      <= '0;
            r_min      <= SAMPLE_CEIL;
            r_max      <= SAMPLE_FLOOR;
            r_first    <= 1'b1;
            r_ev_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_acc      <= n_acc;
            r_idx      <= n_idx;
            r_min      <= n_min;
            r_max      <= n_max;
            r_first    <= n_first;
            r_ev_valid <= n_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev <= n_ev;
    end

    assign o_event_valid = r_ev_valid;
    assign o_event       = r_ev;

endmodule

### hdl/minmax_waveform_column_decimator_unit.sv
// Top level of the min/max waveform column decimator.
// A column word passes in turn through the column event, gain multiply, clamp and output registers.
// Throughput: one sample word per cycle while o_in_stall is low; each sample yields zero or one column word.
// The pipeline is tracker, gain multiply, clamp against the previous column, output.
// Reset (synchronous, active low) loads register defaults and starts a fresh frame.
`timescale 1ns / 1ps

module minmax_waveform_column_decimator_unit #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mmwcd_pkg::t_in_word             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mmwcd_pkg::t_out_word            o_out_word,
    input  logic                            i_cfg_we,
    input  logic [mmwcd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mmwcd_pkg::ZOOM_W-1:0]    i_cfg_wdata
);
    import mmwcd_pkg::*;

    localparam int MAX_CAP = (MAX_COLUMNS > 8191) ? 8191 : MAX_COLUMNS;
    localparam int PROD_W  = SAMPLE_WIDTH + GAIN_W + 1;
    localparam int SHIFT   = SAMPLE_WIDTH + 8;
    localparam int CMP_W   = SCALED_W + 1;
    localparam int DIFF_W  = SCALED_W + 2;
    localparam logic [PROD_W-1:0] BIAS = PROD_W'((64'd1 << SHIFT) - 64'd1);

    // Configuration registers
    logic [ZOOM_W-1:0]  r_samples_per_pixel;
    logic [GAIN_W-1:0]  r_vertical_gain;
    logic [ROW_W-1:0]   r_middle_row;
    logic [COUNT_W-1:0] r_column_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_pixel <= ZOOM_RESET;
            r_vertical_gain     <= GAIN_RESET;
            r_middle_row        <= ROW_RESET;
            r_column_count      <= COUNT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SAMPLES_PER_PIXEL: r_samples_per_pixel <= i_cfg_wdata;
                CFG_VERTICAL_GAIN:     r_vertical_gain     <= i_cfg_wdata[GAIN_W-1:0];
                CFG_MIDDLE_ROW:        r_middle_row        <= i_cfg_wdata[ROW_W-1:0];
                CFG_COLUMN_COUNT:      r_column_count      <= i_cfg_wdata[COUNT_W-1:0];
                default:               r_column_count      <= r_column_count;
            endcase
        end
    end

    logic [COUNT_W-1:0] limit;
    assign limit = (r_column_count < COUNT_W'(MAX_CAP)) ? r_column_count : COUNT_W'(MAX_CAP);

    // Stage enables: a stage moves when it is empty or the one after it moves.
    logic en1, en2, en3, en4;
    logic r_v2, r_v3, r_v4;
    logic ev_valid;
    t_col_event ev;

    assign en4 = !r_v4 || !i_out_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !ev_valid || en2;
    assign o_in_stall = !en1;

    mmwcd_tracker u_tracker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_take             (i_in_valid && en1),
        .i_word             (i_in_word),
        .i_advance          (en1),
        .i_samples_per_pixel(r_samples_per_pixel),
        .i_limit            (limit),
        .o_event_valid      (ev_valid),
        .o_event            (ev)
    );

    // Gain multiply
    logic signed [PROD_W-1:0] r_p_min, r_p_max;
    logic [COUNT_W-1:0]       r_idx2;
    logic                     r_first2;
    logic signed [PROD_W-1:0] gain_ext;

    assign gain_ext = PROD_W'($signed({1'b0, r_vertical_gain}));

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p_min  <= PROD_W'(ev.run_min) * gain_ext;
            r_p_max  <= PROD_W'(ev.run_max) * gain_ext;
            r_idx2   <= ev.index;
            r_first2 <= ev.first;
        end
    end

    // Division by a power of two that truncates toward zero.
    function automatic logic signed [SCALED_W-1:0] scale_down(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        adj = p[PROD_W-1] ? (p + $signed(BIAS)) : p;
        return adj[SHIFT+SCALED_W-1:SHIFT];
    endfunction

    // Clamp so that each column touches the one before it.
    logic signed [SCALED_W-1:0] r_prev_min, r_prev_max;
    logic signed [SCALED_W-1:0] r_c_min, r_c_max;
    logic [COUNT_W-1:0]         r_idx3;
    logic signed [SCALED_W-1:0] sc_min, sc_max, cl_min, cl_max;
    logic signed [CMP_W-1:0]    prev_max_p1, prev_min_m1;

    always_comb begin
        sc_min      = scale_down(r_p_min);
        sc_max      = scale_down(r_p_max);
        prev_max_p1 = CMP_W'(r_prev_max) + CMP_W'(1);
        prev_min_m1 = CMP_W'(r_prev_min) - CMP_W'(1);
        cl_min      = sc_min;
        cl_max      = sc_max;
        if (!r_first2) begin
            if (CMP_W'(sc_min) > prev_max_p1) begin
                cl_min = prev_max_p1[SCALED_W-1:0];
            end
            if (CMP_W'(sc_max) < prev_min_m1) begin
                cl_max = prev_min_m1[SCALED_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_c_min <= cl_min;
            r_c_max <= cl_max;
            r_idx3  <= r_idx2;
        end
        if (en3 && r_v2) begin
            r_prev_min <= cl_min;
            r_prev_max <= cl_max;
        end
    end

    // Output rows, saturated to 16 bits.
    function automatic logic signed [OUT_W-1:0] sat_row(input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] hi_lim, lo_lim;
        hi_lim = DIFF_W'(32767);
        lo_lim = -DIFF_W'(32768);
        if (d > hi_lim) begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end else if (d < lo_lim) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end
        return d[OUT_W-1:0];
    endfunction

    logic signed [DIFF_W-1:0] mid_ext, top_d, bot_d;
    t_out_word                r_out, n_out;

    always_comb begin
        mid_ext          = $signed(DIFF_W'(r_middle_row));
        top_d            = mid_ext - DIFF_W'(r_c_max);
        bot_d            = mid_ext - DIFF_W'(r_c_min);
        n_out.column     = r_idx3[COL_W-1:0];
        n_out.top_row    = sat_row(top_d);
        n_out.bottom_row = sat_row(bot_d);
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en2) r_v2 <= ev_valid;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_word  = r_out;

endmodule
